@@ rtl/zctd_pkg.sv @@
// zctd_pkg: shared constants for the zebra crossing row transition detector
// widths, register indexes, reset values and default image size; no dependencies
package zctd_pkg;

  localparam int unsigned DEF_IMAGE_WIDTH  = 320;
  localparam int unsigned DEF_IMAGE_HEIGHT = 130;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned FRM_W   = 4;
  localparam int unsigned TOT_W   = 16;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned CIDX_W  = 3;

  typedef enum logic [CIDX_W-1:0] {
    REG_ROW_TOP   = 3'd0,
    REG_ROW_BOT   = 3'd1,
    REG_COL_LEFT  = 3'd2,
    REG_COL_RIGHT = 3'd3,
    REG_THRESH    = 3'd4,
    REG_CONFIRM   = 3'd5,
    REG_RELEASE   = 3'd6
  } cfg_reg_t;

  localparam logic [ROW_W-1:0] RST_ROW_TOP   = 8'd30;
  localparam logic [ROW_W-1:0] RST_ROW_BOT   = 8'd125;
  localparam logic [COL_W-1:0] RST_COL_LEFT  = 10'd20;
  localparam logic [COL_W-1:0] RST_COL_RIGHT = 10'd300;
  localparam logic [CNT_W-1:0] RST_THRESH    = 6'd6;
  localparam logic [FRM_W-1:0] RST_CONFIRM   = 4'd2;
  localparam logic [FRM_W-1:0] RST_RELEASE   = 4'd8;

  localparam logic [COL_W-1:0] COL_MAX = '1;
  localparam logic [ROW_W-1:0] ROW_MAX = '1;

endpackage

@@ rtl/zebra_crossing_row_transition_detector_unit.sv @@
// zebra_crossing_row_transition_detector_unit: per-row transition counter and frame debounce
// depends on zctd_pkg
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+--------------------------------------------
//  in      | sink      | in_valid/in_ready   | pixel, end_of_row, end_of_frame, start_marker
//  out     | source    | out_valid/out_ready | detected .. armed, one word per frame
//  cfg     | sink      | cfg_we              | cfg_index, cfg_data
//
// one pixel per cycle: all per-pixel state updates in the accepting cycle, result
// word is registered in the output stage and is valid in the cycle after the frame end
// reset clears position, frame best, streaks, totals and loads the default registers
// only an end_of_frame word waits for a full output stage; other pixels flow on
// while a result is held
module zebra_crossing_row_transition_detector_unit
  import zctd_pkg::*;
#(
  parameter int unsigned IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int unsigned IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              end_of_row,
  input  logic              end_of_frame,
  input  logic              start_marker,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              detected,
  output logic              rising_edge,
  output logic [TOT_W-1:0]  total_detections,
  output logic [CNT_W-1:0]  max_transitions,
  output logic [ROW_W-1:0]  peak_row,
  output logic              row_found,
  output logic              armed,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam logic [COL_W:0] W_LIM = (COL_W+1)'(IMAGE_WIDTH);
  localparam logic [ROW_W:0] H_LIM = (ROW_W+1)'(IMAGE_HEIGHT);

  // configuration
  logic [ROW_W-1:0] row_top, row_bottom;
  logic [COL_W-1:0] col_left, col_right;
  logic [CNT_W-1:0] trans_threshold;
  logic [FRM_W-1:0] confirm_frames, release_frames;

  // state
  logic             armed_latch, detected_flag;
  logic [FRM_W-1:0] hit_streak, miss_streak;
  logic [TOT_W-1:0] detection_total;
  logic [COL_W-1:0] column_counter;
  logic [ROW_W-1:0] row_counter;
  logic [PIX_W-1:0] previous_pixel;
  logic [CNT_W-1:0] row_transitions;
  logic [CNT_W-1:0] frame_best_count;
  logic [ROW_W-1:0] frame_best_row;
  logic             frame_best_valid;

  logic             accept, row_end;
  logic             row_in_win, col_in_win;
  logic [COL_W:0]   x_lo, x_hi;
  logic [CNT_W-1:0] row_trans_next;
  logic             best_take;
  logic [CNT_W-1:0] best_count_next;
  logic [ROW_W-1:0] peak_row_next;
  logic             best_valid_next;
  logic             armed_next, hit;
  logic [FRM_W-1:0] hit_streak_next, miss_streak_next;
  logic             detected_next, rising_next;
  logic [TOT_W-1:0] total_next;

  assign in_ready = !end_of_frame || !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign row_end  = end_of_row || end_of_frame;

  always_comb begin
    x_lo = (col_left == '0) ? (COL_W+1)'(2) : ({1'b0, col_left} + 1'b1);
    x_hi = ({1'b0, col_right} > W_LIM) ? W_LIM : {1'b0, col_right};
    row_in_win = (row_counter >= row_top) && (row_counter < row_bottom)
                 && ({1'b0, row_counter} < H_LIM);
    col_in_win = ({1'b0, column_counter} >= x_lo) && ({1'b0, column_counter} < x_hi);

    row_trans_next = row_transitions;
    if (row_in_win && col_in_win && (pixel != previous_pixel)
        && (row_transitions < trans_threshold)) begin
      row_trans_next = row_transitions + 1'b1;
    end

    best_take = row_in_win && (row_trans_next != '0) && (row_trans_next >= frame_best_count);
    best_count_next = best_take ? row_trans_next : frame_best_count;
    peak_row_next   = best_take ? row_counter    : frame_best_row;
    best_valid_next = best_take || frame_best_valid;

    // frame-end debounce
    armed_next       = armed_latch || start_marker;
    hit              = armed_next && (best_count_next >= trans_threshold);
    hit_streak_next  = '0;
    miss_streak_next = '0;
    if (hit) begin
      hit_streak_next = (hit_streak < confirm_frames) ? hit_streak + 1'b1 : hit_streak;
    end else begin
      miss_streak_next = (miss_streak < release_frames) ? miss_streak + 1'b1 : miss_streak;
    end
    detected_next = detected_flag;
    rising_next   = 1'b0;
    total_next    = detection_total;
    if (armed_next && !detected_flag && (hit_streak_next >= confirm_frames)) begin
      detected_next = 1'b1;
      rising_next   = 1'b1;
      total_next    = detection_total + 1'b1;
    end else if (detected_flag && (miss_streak_next >= release_frames)) begin
      detected_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_top          <= RST_ROW_TOP;
      row_bottom       <= RST_ROW_BOT;
      col_left         <= RST_COL_LEFT;
      col_right        <= RST_COL_RIGHT;
      trans_threshold  <= RST_THRESH;
      confirm_frames   <= RST_CONFIRM;
      release_frames   <= RST_RELEASE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_TOP:   row_top         <= cfg_data[ROW_W-1:0];
        REG_ROW_BOT:   row_bottom      <= cfg_data[ROW_W-1:0];
        REG_COL_LEFT:  col_left        <= cfg_data[COL_W-1:0];
        REG_COL_RIGHT: col_right       <= cfg_data[COL_W-1:0];
        REG_THRESH:    trans_threshold <= cfg_data[CNT_W-1:0];
        REG_CONFIRM:   confirm_frames  <= cfg_data[FRM_W-1:0];
        REG_RELEASE:   release_frames  <= cfg_data[FRM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_latch      <= 1'b0;
      detected_flag    <= 1'b0;
      hit_streak       <= '0;
      miss_streak      <= '0;
      detection_total  <= '0;
      column_counter   <= '0;
      row_counter      <= '0;
      previous_pixel   <= '0;
      row_transitions  <= '0;
      frame_best_count <= '0;
      frame_best_row   <= '0;
      frame_best_valid <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (accept && end_of_frame) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        previous_pixel <= end_of_frame ? '0 : pixel;
        if (!row_end) begin
          row_transitions <= row_trans_next;
          if (column_counter != COL_MAX) begin
            column_counter <= column_counter + 1'b1;
          end
        end else if (!end_of_frame) begin
          row_transitions  <= '0;
          column_counter   <= '0;
          frame_best_count <= best_count_next;
          frame_best_row   <= peak_row_next;
          frame_best_valid <= best_valid_next;
          if (row_counter != ROW_MAX) begin
            row_counter <= row_counter + 1'b1;
          end
        end else begin
          // frame end: emit the word and start a fresh frame
          column_counter   <= '0;
          row_counter      <= '0;
          row_transitions  <= '0;
          frame_best_count <= '0;
          frame_best_row   <= '0;
          frame_best_valid <= 1'b0;
          armed_latch      <= armed_next;
          hit_streak       <= hit_streak_next;
          miss_streak      <= miss_streak_next;
          detected_flag    <= detected_next;
          detection_total  <= total_next;
        end
      end
    end
  end

  // output word, no reset needed
  always_ff @(posedge clk) begin
    if (accept && end_of_frame) begin
      detected         <= detected_next;
      rising_edge      <= rising_next;
      total_detections <= total_next;
      max_transitions  <= armed_next ? best_count_next : '0;
      peak_row         <= (armed_next && best_valid_next) ? peak_row_next : '0;
      row_found        <= armed_next && best_valid_next;
      armed            <= armed_next;
    end
  end

endmodule
